// ===== rtl/twcw_pkg.sv =====
// Package for the textured wall column walker.
// Channel payload structs, setup result bundle, sequencer states and codes.
// No dependencies.
package twcw_pkg;

  // Configuration register indexes
  localparam logic CFG_CEILING = 1'b0;
  localparam logic CFG_FLOOR   = 1'b1;

  // Pixel region codes
  localparam logic [1:0] REGION_CEILING = 2'd0;
  localparam logic [1:0] REGION_WALL    = 2'd1;
  localparam logic [1:0] REGION_FLOOR   = 2'd2;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  // Serial unit sizes
  localparam int DIV_STEPS  = 25;  // quotient bits of (TEXTURE_HEIGHT << 16) / proj_height
  localparam int DIR_BITS   = 16;  // multiplier bits of the wall hit product
  localparam int STEP_BITS  = 24;  // multiplier bits of the accumulator start product
  localparam logic [24:0] STEP_MAX = 25'h0FF_FFFF;

  typedef struct packed {
    logic               cmd;
    logic [9:0]         column;
    logic               wall_side;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [23:0]        pos_x;
    logic [23:0]        pos_y;
    logic [23:0]        wall_dist;
    logic [15:0]        proj_height;
    logic [8:0]         span_start;
    logic [9:0]         span_end;
  } req_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [8:0]  out_row;
    logic [1:0]  region;
    logic [1:0]  texture_id;
    logic [5:0]  tex_col;
    logic [5:0]  tex_row;
    logic [23:0] fill_color;
    logic        last_row;
  } pix_t;

  // Column setup results handed to the walker
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [1:0]  texture;
    logic [5:0]  tex_col;
    logic [23:0] tex_step;
    logic [31:0] tex_accum;
  } setup_res_t;

  typedef enum logic [1:0] {
    SU_IDLE,
    SU_DIVIDE,
    SU_SCALE,
    SU_DONE
  } su_state_t;

endpackage

// ===== rtl/twcw_setup.sv =====
// Column setup unit: texture choice, texture column, row step and start accumulator.
// Shift-and-add multipliers and a restoring divider, one bit per cycle.
// Depends on twcw_pkg.
module twcw_setup import twcw_pkg::*; #(
  parameter int SCREEN_HEIGHT  = 512,
  parameter int TEXTURE_WIDTH  = 64,
  parameter int TEXTURE_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  req_t       req,
  output setup_res_t res
);

  localparam logic [24:0] DIVIDEND = 25'(TEXTURE_HEIGHT * 65536);
  localparam logic [17:0] HALF_SCREEN = 18'(SCREEN_HEIGHT / 2);

  su_state_t state, state_next;
  logic [4:0] cnt;

  // Hit product: pos * 2^14 + dist * dir, kept modulo 2^30
  logic [29:0] hit_acc;
  logic [29:0] hit_mcand;
  logic [15:0] hit_mplier;

  // Restoring divider
  logic [15:0] divisor;
  logic [15:0] rem;
  logic [24:0] dvd;
  logic [24:0] quot;
  logic [24:0] quot_next;
  logic [16:0] trial;
  logic        trial_ok;

  // Start accumulator product, modulo 2^32
  logic [31:0] acc_sum;
  logic [31:0] acc_mcand;
  logic [23:0] acc_mplier;

  logic [1:0]  texture;
  logic        mirror;
  logic [8:0]  span_start;
  logic [5:0]  tex_col;
  logic [23:0] tex_step;

  // Derived values at the end of the divide phase
  logic [15:0] frac;
  logic [24:0] col_prod;
  logic [8:0]  tx;
  logic [8:0]  tx_sel;
  logic [23:0] step_sat;
  logic [17:0] offs;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SU_IDLE:   if (start) state_next = SU_DIVIDE;
      SU_DIVIDE: if (cnt == 5'(DIV_STEPS - 1)) state_next = SU_SCALE;
      SU_SCALE:  if (cnt == 5'(STEP_BITS - 1)) state_next = SU_DONE;
      SU_DONE:   state_next = SU_IDLE;
      default:   state_next = SU_IDLE;
    endcase
  end

  // Divider step; quot_next holds the full quotient on the last divide cycle
  assign trial     = {rem, dvd[24]};
  assign trial_ok  = trial >= {1'b0, divisor};
  assign quot_next = {quot[23:0], trial_ok};

  // Texture column from the hit fraction
  assign frac     = hit_acc[29:14];
  assign col_prod = {9'b0, frac} * 25'(TEXTURE_WIDTH);
  assign tx       = col_prod[24:16];
  assign tx_sel   = mirror ? 9'(TEXTURE_WIDTH - 1) - tx : tx;
  assign step_sat = (quot_next > STEP_MAX) ? STEP_MAX[23:0] : quot_next[23:0];
  assign offs     = {9'b0, span_start} - HALF_SCREEN + {3'b0, divisor[15:1]};

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (state)
        SU_IDLE: begin
          cnt <= '0;
          if (start) begin
            span_start <= req.span_start;
            divisor    <= (req.proj_height == 16'd0) ? 16'd1 : req.proj_height;
            rem        <= '0;
            dvd        <= DIVIDEND;
            quot       <= '0;
            hit_mcand  <= {6'b0, req.wall_dist};
            if (req.wall_side == 1'b0) begin
              texture    <= (req.dir_x > 16'sd0) ? 2'd0 : 2'd1;
              mirror     <= req.dir_x > 16'sd0;
              hit_acc    <= {req.pos_y[15:0], 14'b0};
              hit_mplier <= req.dir_y;
            end else begin
              texture    <= (req.dir_y > 16'sd0) ? 2'd2 : 2'd3;
              mirror     <= req.dir_y < 16'sd0;
              hit_acc    <= {req.pos_x[15:0], 14'b0};
              hit_mplier <= req.dir_x;
            end
          end
        end
        SU_DIVIDE: begin
          // One quotient bit per cycle
          rem  <= trial_ok ? 16'(trial - {1'b0, divisor}) : trial[15:0];
          dvd  <= {dvd[23:0], 1'b0};
          quot <= quot_next;
          // One multiplier bit per cycle; the sign bit weighs negative
          if (cnt < 5'(DIR_BITS)) begin
            if (hit_mplier[0]) begin
              hit_acc <= (cnt == 5'(DIR_BITS - 1)) ? hit_acc - hit_mcand
                                                   : hit_acc + hit_mcand;
            end
            hit_mcand  <= {hit_mcand[28:0], 1'b0};
            hit_mplier <= {1'b0, hit_mplier[15:1]};
          end
          if (cnt == 5'(DIV_STEPS - 1)) begin
            cnt        <= '0;
            tex_col    <= tx_sel[5:0];
            tex_step   <= step_sat;
            acc_mplier <= step_sat;
            acc_mcand  <= {{14{offs[17]}}, offs};
            acc_sum    <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        SU_SCALE: begin
          if (acc_mplier[0]) acc_sum <= acc_sum + acc_mcand;
          acc_mcand  <= {acc_mcand[30:0], 1'b0};
          acc_mplier <= {1'b0, acc_mplier[23:1]};
          cnt        <= cnt + 5'd1;
        end
        default: cnt <= '0;
      endcase
    end
  end

  assign res.busy      = state != SU_IDLE;
  assign res.done      = state == SU_DONE;
  assign res.texture   = texture;
  assign res.tex_col   = tex_col;
  assign res.tex_step  = tex_step;
  assign res.tex_accum = acc_sum;

endmodule

// ===== rtl/textured_wall_column_walker.sv =====
// Textured wall column walker: renders one raycaster screen column a pixel at a time.
// Top level: request and pixel channels, color registers, row walk, output register.
// Depends on twcw_pkg and twcw_setup.
//
// Usage: send a load request (cmd 0) with the ray hit, then one next request (cmd 1)
// per pixel. Each next request yields one pixel transfer on the pix channel for rows
// 0 .. SCREEN_HEIGHT-1, the last one flagged with last_row. Requests with no column
// loaded, or past the end of the column, are taken and yield nothing; so are the
// pixels of a column at or beyond SCREEN_WIDTH.
// Setup: a load holds req_ready low while the setup unit runs its bit-serial
// divider with the 16-bit hit multiply beside it, then a serial multiply for the
// start accumulator, then a hand-off state.
// A next request's pixel appears in the output register the cycle after the
// transfer, and next requests stream at one per cycle while pix_ready is high.
// Stall: while a pixel waits in the output register and pix_ready is low, req_ready
// is low; the output holds steady.
// Reset: no column loaded, output empty, both fill colors zero. Color writes on
// cfg_en apply from the next pixel.
module textured_wall_column_walker import twcw_pkg::*; #(
  parameter int SCREEN_HEIGHT  = 512,
  parameter int SCREEN_WIDTH   = 1024,
  parameter int TEXTURE_WIDTH  = 64,
  parameter int TEXTURE_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        pix_valid,
  input  logic        pix_ready,
  output pix_t        pix,
  input  logic        cfg_en,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  setup_res_t su;
  logic       take;
  logic       take_load;
  logic       take_next;

  logic [23:0] ceiling_color;
  logic [23:0] floor_fill;

  logic        active;
  logic [9:0]  row_counter;
  logic [31:0] tex_accum;
  logic [23:0] tex_step;
  logic [5:0]  held_tex_col;
  logic [1:0]  held_texture;
  logic [9:0]  held_span_start;
  logic [9:0]  held_span_end;
  logic [9:0]  held_column;

  logic [10:0] row_inc;
  logic        is_last;
  logic        in_ceiling;
  logic        in_wall;
  logic        col_visible;
  logic [15:0] row_int;

  assign req_ready = !su.busy && (!pix_valid || pix_ready);
  assign take      = req_valid && req_ready;
  assign take_load = take && (req.cmd == CMD_LOAD);
  assign take_next = take && (req.cmd == CMD_NEXT);

  twcw_setup #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEXTURE_WIDTH (TEXTURE_WIDTH),
    .TEXTURE_HEIGHT(TEXTURE_HEIGHT)
  ) u_setup (
    .clk  (clk),
    .rst  (rst),
    .start(take_load),
    .req  (req),
    .res  (su)
  );

  // Color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_color <= '0;
      floor_fill    <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_CEILING: ceiling_color <= cfg_data;
        CFG_FLOOR:   floor_fill    <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Row classification
  assign row_inc     = {1'b0, row_counter} + 11'd1;
  assign is_last     = row_inc >= 11'(SCREEN_HEIGHT);
  assign in_ceiling  = row_counter < held_span_start;
  assign in_wall     = row_counter < held_span_end;
  assign col_visible = {1'b0, held_column} < 11'(SCREEN_WIDTH);
  assign row_int     = tex_accum[31:16] & 16'(TEXTURE_HEIGHT - 1);

  // Column walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      row_counter <= '0;
    end else if (take_load) begin
      active          <= 1'b0;
      held_span_start <= {1'b0, req.span_start};
      held_span_end   <= req.span_end;
      held_column     <= req.column;
    end else if (su.done) begin
      active       <= 1'b1;
      row_counter  <= '0;
      tex_accum    <= su.tex_accum;
      tex_step     <= su.tex_step;
      held_tex_col <= su.tex_col;
      held_texture <= su.texture;
    end else if (take_next && active) begin
      row_counter <= row_inc[9:0];
      if (is_last) active <= 1'b0;
      if (!in_ceiling && in_wall) tex_accum <= tex_accum + {8'b0, tex_step};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_ready) pix_valid <= 1'b0;
      if (take_next && active && col_visible) pix_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_next && active) begin
      pix.out_column <= held_column;
      pix.out_row    <= row_counter[8:0];
      pix.last_row   <= is_last;
      if (in_ceiling) begin
        pix.region     <= REGION_CEILING;
        pix.texture_id <= '0;
        pix.tex_col    <= '0;
        pix.tex_row    <= '0;
        pix.fill_color <= ceiling_color;
      end else if (in_wall) begin
        pix.region     <= REGION_WALL;
        pix.texture_id <= held_texture;
        pix.tex_col    <= held_tex_col;
        pix.tex_row    <= row_int[5:0];
        pix.fill_color <= '0;
      end else begin
        pix.region     <= REGION_FLOOR;
        pix.texture_id <= '0;
        pix.tex_col    <= '0;
        pix.tex_row    <= '0;
        pix.fill_color <= floor_fill;
      end
    end
  end

endmodule
